// ===== rtl/command_line_tokenizer_assert.svh =====
// ---------------------------------------------------------------------------
// Command line tokenizer assertion macros
// Clocked assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Implication checked at every rising edge outside reset.
`define CT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define CT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CT_ASSERT(label, clk, rst_n, prop, msg)
`define CT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/cmdtok_pkg.sv =====
// ---------------------------------------------------------------------------
// Command line tokenizer package
// Payload types, scan modes and character codes.
// ---------------------------------------------------------------------------
`default_nettype none

package cmdtok_pkg;

	typedef struct packed {
		logic [7:0] char_in;
		logic       line_end;
	} char_item_t;

	typedef struct packed {
		logic       has_char;
		logic [7:0] out_char;
		logic       token_end;
		logic       key_flag;
		logic       brace_flag;
		logic       array_flag;
	} tok_item_t;

	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'b001,
		MODE_WORD    = 3'b010,
		MODE_STRING  = 3'b100
	} scan_mode_t;

	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_LT       = 8'h3C;
	localparam logic [7:0] CH_GT       = 8'h3E;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_BAR      = 8'h7C;

endpackage

`default_nettype wire

// ===== rtl/command_line_tokenizer.sv =====
// ---------------------------------------------------------------------------
// Command line tokenizer
// Splits a character stream into tokens with key, brace and array flags.
// ---------------------------------------------------------------------------
// The input register holds a character; the result register holds its result.
// Throughput: one character per cycle unless tok_ready holds back a result;
// the scan state updates as the input register's character passes to the result.
// Reset: arst_n clears both registers' valid bits and the scan state
// (between tokens, no skip, no group, empty token).
`default_nettype none

`include "command_line_tokenizer_assert.svh"

module command_line_tokenizer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_ready,
	input  cmdtok_pkg::char_item_t char_data,
	output logic                   tok_valid,
	input  logic                   tok_ready,
	output cmdtok_pkg::tok_item_t  tok_data
);

	logic                   valid_s1;
	cmdtok_pkg::char_item_t char_s1;

	cmdtok_pkg::scan_mode_t mode_q, mode_d;
	logic skip_q, skip_d;
	logic brace_q, brace_d;
	logic array_q, array_d;
	logic nonempty_q, nonempty_d;

	logic                  res_valid_q;
	cmdtok_pkg::tok_item_t res_q;

	logic                  emit;
	cmdtok_pkg::tok_item_t res_d;
	logic                  word_go;
	logic                  word_ne;
	logic                  out_free;
	logic                  process;
	logic [7:0]            c;

	assign c        = char_s1.char_in;
	assign out_free = !res_valid_q || tok_ready;
	assign process  = valid_s1 && (!emit || out_free);

	assign char_ready = !valid_s1 || process;
	assign tok_valid  = res_valid_q;
	assign tok_data   = res_q;

	always_comb begin
		mode_d     = mode_q;
		skip_d     = skip_q;
		brace_d    = brace_q;
		array_d    = array_q;
		nonempty_d = nonempty_q;
		emit       = 1'b0;
		res_d      = '0;
		word_go    = 1'b0;
		word_ne    = nonempty_q;

		if (char_s1.line_end) begin
			if ((mode_q == cmdtok_pkg::MODE_WORD || mode_q == cmdtok_pkg::MODE_STRING)
			    && nonempty_q) begin
				emit             = 1'b1;
				res_d.token_end  = 1'b1;
				res_d.brace_flag = brace_q;
				res_d.array_flag = array_q;
			end
			mode_d     = cmdtok_pkg::MODE_BETWEEN;
			skip_d     = 1'b0;
			brace_d    = 1'b0;
			array_d    = 1'b0;
			nonempty_d = 1'b0;
		end else if (skip_q) begin
			skip_d = 1'b0;
		end else begin
			case (mode_q)
				cmdtok_pkg::MODE_STRING: begin
					if (c == cmdtok_pkg::CH_QUOTE) begin
						skip_d     = 1'b1;
						mode_d     = cmdtok_pkg::MODE_BETWEEN;
						nonempty_d = 1'b0;
						if (nonempty_q) begin
							emit             = 1'b1;
							res_d.token_end  = 1'b1;
							res_d.brace_flag = brace_q;
							res_d.array_flag = array_q;
						end
					end else begin
						nonempty_d     = 1'b1;
						emit           = 1'b1;
						res_d.has_char = 1'b1;
						res_d.out_char = c;
					end
				end
				cmdtok_pkg::MODE_WORD: begin
					word_go = 1'b1;
				end
				default: begin
					mode_d = cmdtok_pkg::MODE_BETWEEN;
					if (c == cmdtok_pkg::CH_QUOTE) begin
						mode_d     = cmdtok_pkg::MODE_STRING;
						nonempty_d = 1'b0;
					end else if (array_q) begin
						if (c == cmdtok_pkg::CH_RBRACKET) begin
							array_d = 1'b0;
						end else begin
							word_go = 1'b1;
						end
					end else if (brace_q) begin
						if (c == cmdtok_pkg::CH_RBRACE) begin
							brace_d = 1'b0;
						end else if (c == cmdtok_pkg::CH_LBRACKET) begin
							array_d = 1'b1;
						end else begin
							word_go = 1'b1;
						end
					end else begin
						if (c == cmdtok_pkg::CH_LBRACE) begin
							brace_d = 1'b1;
						end else if (c == cmdtok_pkg::CH_LBRACKET) begin
							array_d = 1'b1;
						end else if (c != cmdtok_pkg::CH_BAR) begin
							word_go = 1'b1;
						end
					end
					word_ne = 1'b0;
				end
			endcase

			if (word_go) begin
				res_d.brace_flag = brace_q;
				res_d.array_flag = array_q;
				mode_d           = cmdtok_pkg::MODE_BETWEEN;
				nonempty_d       = 1'b0;
				emit             = word_ne;
				res_d.token_end  = 1'b1;
				case (c)
					cmdtok_pkg::CH_SPACE, cmdtok_pkg::CH_COMMA: begin
					end
					cmdtok_pkg::CH_COLON: begin
						res_d.key_flag = 1'b1;
					end
					cmdtok_pkg::CH_LT, cmdtok_pkg::CH_GT: begin
						emit           = 1'b1;
						res_d.has_char = 1'b1;
						res_d.out_char = c;
					end
					cmdtok_pkg::CH_RBRACKET: begin
						array_d = 1'b0;
					end
					cmdtok_pkg::CH_RBRACE: begin
						if (brace_q && !array_q) begin
							brace_d = 1'b0;
						end
					end
					default: begin
						mode_d           = cmdtok_pkg::MODE_WORD;
						nonempty_d       = 1'b1;
						emit             = 1'b1;
						res_d            = '0;
						res_d.has_char   = 1'b1;
						res_d.out_char   = c;
					end
				endcase
				if (!res_d.token_end) begin
					res_d.brace_flag = 1'b0;
					res_d.array_flag = 1'b0;
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= char_data;
		end
	end

	// scan state: advance when the registered character is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= cmdtok_pkg::MODE_BETWEEN;
			skip_q     <= 1'b0;
			brace_q    <= 1'b0;
			array_q    <= 1'b0;
			nonempty_q <= 1'b0;
		end else if (process) begin
			mode_q     <= mode_d;
			skip_q     <= skip_d;
			brace_q    <= brace_d;
			array_q    <= array_d;
			nonempty_q <= nonempty_d;
		end
	end

	// result register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= process && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && process && emit) begin
			res_q <= res_d;
		end
	end

	`CT_NEVER(a_key_with_char, clk, arst_n,
		res_valid_q && res_q.key_flag && res_q.has_char,
		"key token carries a character")
	`CT_NEVER(a_flags_without_end, clk, arst_n,
		res_valid_q && !res_q.token_end
		&& (res_q.key_flag || res_q.brace_flag || res_q.array_flag),
		"flags set without token end")
	`CT_ASSERT(a_skip_between, clk, arst_n,
		skip_q |-> (mode_q == cmdtok_pkg::MODE_BETWEEN),
		"skip pending outside between-token mode")
	`CT_ASSERT(a_nonempty_mode, clk, arst_n,
		nonempty_q |-> (mode_q != cmdtok_pkg::MODE_BETWEEN),
		"nonempty token between tokens")

endmodule

`default_nettype wire
